FILE: src/sroe_pkg.sv
`default_nettype none
package sroe_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned IDX_W     = 8;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_GET    = 2'd2,
    OP_SEND   = 2'd3
  } op_t;

  typedef struct packed {
    logic ok;
    logic bit_state;
    logic serial_valid;
    logic serial_data;
    logic last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic bit_op;      // request gives one result now
    logic send_start;  // load the shift counter
    logic send_bit;    // emit the bit under the counter
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic chips_zero;  // no chips in use
    logic cnt_zero;    // shift counter on the final bit
  } status_t;

endpackage
`default_nettype wire

FILE: src/sroe_ifs.sv
`default_nettype none
interface sroe_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [sroe_pkg::IDX_W-1:0]  bit_index;
  logic                        bit_value;

  modport source (output valid, output operation, output bit_index, output bit_value,
                  input ready);
  modport sink   (input valid, input operation, input bit_index, input bit_value,
                  output ready);
endinterface

interface sroe_out_if;
  logic valid;
  logic ready;
  logic ok;
  logic bit_state;
  logic serial_valid;
  logic serial_data;
  logic last;

  modport source (output valid, output ok, output bit_state, output serial_valid,
                  output serial_data, output last, input ready);
  modport sink   (input valid, input ok, input bit_state, input serial_valid,
                  input serial_data, input last, output ready);
endinterface
`default_nettype wire

FILE: src/shift_register_output_expander.sv
// channel | dir | payload                                         | handshake
// in_ch   | in  | operation[1:0], bit_index[7:0], bit_value        | valid/ready
// out_ch  | out | ok, bit_state, serial_valid, serial_data, last   | valid/ready
// cfg     | in  | cfg_wdata[3:0] = num_chips                       | cfg_we, no wait
//
// set, toggle and get give one result each; back to back at one per cycle while the output is free
// send shifts out all bits of the num_chips bytes, one bit per cycle while the output is free,
// from the shift counter over the image register file; a send with no chips gives one result
// synchronous active-low reset clears the image, num_chips and the output valid flag
// a stalled output holds its result; input is refused while a send is shifting out
`default_nettype none
module shift_register_output_expander #(
  parameter int unsigned MAX_CHIPS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  sroe_in_if.sink                         in_ch,
  sroe_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [sroe_pkg::CFG_W-1:0] cfg_wdata
);

  sroe_pkg::cmd_t    cmd;
  sroe_pkg::status_t status;
  sroe_pkg::result_t result;
  logic              out_valid;

  // sequencing: idle / shifting a send out
  sroe_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // image, chip count, shift counter and output register
  sroe_dp #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_ch.operation),
    .in_bit_index (in_ch.bit_index),
    .in_bit_value (in_ch.bit_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .out_result   (result)
  );

  // result fields onto the output channel
  assign out_ch.valid        = out_valid;
  assign out_ch.ok           = result.ok;
  assign out_ch.bit_state    = result.bit_state;
  assign out_ch.serial_valid = result.serial_valid;
  assign out_ch.serial_data  = result.serial_data;
  assign out_ch.last         = result.last;

endmodule
`default_nettype wire

FILE: src/sroe_ctrl.sv
`default_nettype none
module sroe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_operation,
  output logic                   in_ready,
  input  wire sroe_pkg::status_t status,
  output sroe_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_send;

  assign in_ready = (state_r == S_IDLE) && status.slot_free;
  assign accept   = in_valid && in_ready;
  assign is_send  = (in_operation == sroe_pkg::OP_SEND);

  always_comb begin
    cmd.bit_op     = accept && (!is_send || status.chips_zero);
    cmd.send_start = accept && is_send && !status.chips_zero;
    cmd.send_bit   = (state_r == S_SEND) && status.slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.send_start) state_nxt = S_SEND;
      end
      S_SEND: begin
        if (cmd.send_bit && status.cnt_zero) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/sroe_dp.sv
`default_nettype none
module sroe_dp #(
  parameter int unsigned MAX_CHIPS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [sroe_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [sroe_pkg::IDX_W-1:0]  in_bit_index,
  input  wire logic                        in_bit_value,
  input  wire sroe_pkg::cmd_t              cmd,
  output sroe_pkg::status_t                status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output sroe_pkg::result_t                out_result
);

  localparam int unsigned CHIP_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int unsigned CNT_W  = CHIP_W + sroe_pkg::POS_W;
  localparam int unsigned HI_W   = sroe_pkg::IDX_W - sroe_pkg::POS_W;

  logic [sroe_pkg::BYTE_BITS-1:0] image_r [MAX_CHIPS];
  logic [sroe_pkg::CFG_W-1:0]     num_chips_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           out_valid_r;
  sroe_pkg::result_t              result_r, result_nxt;

  logic [sroe_pkg::CFG_W-1:0]     chips;
  logic [HI_W-1:0]                idx_chip;
  logic [sroe_pkg::POS_W-1:0]     idx_pos;
  logic                           in_range;
  logic [CHIP_W-1:0]              rd_chip;
  logic [sroe_pkg::POS_W-1:0]     rd_pos;
  logic [sroe_pkg::BYTE_BITS-1:0] rd_byte;
  logic                           rd_bit;
  logic [CHIP_W-1:0]              top_chip;

  // clamp to the chips actually built
  assign chips = (num_chips_r > sroe_pkg::CFG_W'(MAX_CHIPS)) ?
                 sroe_pkg::CFG_W'(MAX_CHIPS) : num_chips_r;

  assign idx_chip = in_bit_index[sroe_pkg::IDX_W-1:sroe_pkg::POS_W];
  assign idx_pos  = in_bit_index[sroe_pkg::POS_W-1:0];
  assign in_range = HI_W'(chips) > idx_chip;

  // single read port shared by bit ops and shifting
  assign rd_chip = cmd.send_bit ? cnt_r[CNT_W-1:sroe_pkg::POS_W] : CHIP_W'(idx_chip);
  assign rd_pos  = cmd.send_bit ? cnt_r[sroe_pkg::POS_W-1:0] : idx_pos;
  assign rd_byte = image_r[rd_chip];
  assign rd_bit  = rd_byte[rd_pos];

  assign top_chip = CHIP_W'(chips - sroe_pkg::CFG_W'(1));

  assign status.slot_free  = !out_valid_r || out_ready;
  assign status.chips_zero = (chips == '0);
  assign status.cnt_zero   = (cnt_r == '0);

  always_comb begin
    result_nxt = result_r;
    if (cmd.bit_op) begin
      result_nxt.serial_valid = 1'b0;
      result_nxt.serial_data  = 1'b0;
      result_nxt.last         = 1'b1;
      if (in_operation == sroe_pkg::OP_SEND) begin
        result_nxt.ok        = 1'b1;
        result_nxt.bit_state = 1'b0;
      end else begin
        result_nxt.ok        = in_range;
        result_nxt.bit_state = in_range && (in_operation == sroe_pkg::OP_GET) && rd_bit;
      end
    end else if (cmd.send_bit) begin
      result_nxt.ok           = 1'b1;
      result_nxt.bit_state    = 1'b0;
      result_nxt.serial_valid = 1'b1;
      result_nxt.serial_data  = rd_bit;
      result_nxt.last         = (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_chips_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < MAX_CHIPS; i++) begin
        image_r[i] <= '0;
      end
    end else begin
      if (cfg_we) num_chips_r <= cfg_wdata;
      if (cmd.bit_op || cmd.send_bit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.send_start) begin
        cnt_r <= {top_chip, {sroe_pkg::POS_W{1'b1}}};
      end else if (cmd.send_bit) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.bit_op && in_range) begin
        case (in_operation)
          sroe_pkg::OP_SET:    image_r[rd_chip][idx_pos] <= in_bit_value;
          sroe_pkg::OP_TOGGLE: image_r[rd_chip][idx_pos] <= !rd_bit;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire
